>>> hw/rtl/pse_pkg.sv
package pse_pkg;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_CARET = 8'h5E;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_UNDERFLOW = 3'd1;
  localparam logic [2:0] ST_OVERFLOW  = 3'd2;
  localparam logic [2:0] ST_DIVZERO   = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_EXEC    = 8'b0000_0010,
    S_DIV     = 8'b0000_0100,
    S_DFIX    = 8'b0000_1000,
    S_POW_MUL = 8'b0001_0000,
    S_POW_SQ  = 8'b0010_0000,
    S_EMIT    = 8'b0100_0000,
    S_SPARE   = 8'b1000_0000
  } state_t;

endpackage

>>> hw/rtl/pse_ram.sv
module pse_ram
  #(parameter int WIDTH = 32,
    parameter int DEPTH = 32)
  (input  logic                     clk,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/postfix_stack_evaluator_unit.sv
// Digit, ignored char or short-stack operator: S_IDLE only; + - * add S_EXEC; / and %
// add the S_DIV loop and S_DFIX (skipped on a zero divisor); ^ adds the S_POW_MUL/S_POW_SQ
// loop (one shared 32x32 multiplier, two passes per exponent bit; skipped on a negative
// exponent). The last char passes through S_EMIT for the result transfer; one char in
// flight at a time, and a waiting result stalls input only when the next expression ends.
// rst (sync, active high) clears depth, error and control; stack RAM is left uninitialized.
module postfix_stack_evaluator_unit
  import pse_pkg::*;
  #(parameter int STACK_DEPTH = 32)
  (input  logic        clk,
   input  logic        rst,
   input  logic        s_axis_tvalid,
   output logic        s_axis_tready,
   input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
   input  logic        s_axis_tlast,   // end_of_expr
   output logic        m_axis_tvalid,
   input  logic        m_axis_tready,
   output logic [39:0] m_axis_tdata);  // [31:0] value, [34:32] status, rest 0

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DW = $clog2(STACK_DEPTH + 1);

  state_t          state, state_next;
  logic [DW-1:0]   depth;
  logic [2:0]      err;
  logic [31:0]     top;
  logic [31:0]     opa;
  logic [31:0]     opb;
  logic [31:0]     rem;
  logic [31:0]     quo;
  logic [4:0]      div_cnt;
  logic [7:0]      op;
  logic            last;
  logic            ysign, xsign;

  logic            accept;
  logic            is_digit, is_op;
  logic [DW-1:0]   depth_m1, depth_m2;
  logic            ram_we, ram_re;
  logic [31:0]     ram_rdata;
  logic [31:0]     mul_a, mul_b, mul_p;
  logic [32:0]     div_sh, div_trial;
  logic [2:0]      err_div, err_und, err_ovf;
  logic            out_free;

  assign s_axis_tready = (state == S_IDLE);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign is_digit = (s_axis_tdata >= CH_ZERO) && (s_axis_tdata <= CH_NINE);
  assign is_op    = (s_axis_tdata == CH_PLUS) || (s_axis_tdata == CH_MINUS) ||
                    (s_axis_tdata == CH_STAR) || (s_axis_tdata == CH_SLASH) ||
                    (s_axis_tdata == CH_PCT)  || (s_axis_tdata == CH_CARET);
  assign depth_m1 = depth - DW'(1);
  assign depth_m2 = depth - DW'(2);
  assign out_free = !m_axis_tvalid || m_axis_tready;

  assign err_div = (err == ST_OK) ? ST_DIVZERO   : err;
  assign err_und = (err == ST_OK) ? ST_UNDERFLOW : err;
  assign err_ovf = (err == ST_OK) ? ST_OVERFLOW  : err;

  assign ram_we = accept && is_digit && (depth < DW'(STACK_DEPTH)) && (depth != '0);
  assign ram_re = accept && is_op && (depth >= DW'(2));

  pse_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (depth_m1[AW-1:0]),
    .wdata (top),
    .re    (ram_re),
    .raddr (depth_m2[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    unique case (state)
      S_POW_MUL: begin
        mul_a = quo;
        mul_b = opa;
      end
      S_POW_SQ: begin
        mul_a = opa;
        mul_b = opa;
      end
      default: begin
        mul_a = ram_rdata;
        mul_b = top;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign div_sh    = {rem, quo[31]};
  assign div_trial = div_sh - {1'b0, opb};

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (is_op && (depth >= DW'(2))) begin
            state_next = S_EXEC;
          end else if (s_axis_tlast) begin
            state_next = S_EMIT;
          end
        end
      end
      S_EXEC: begin
        if ((op == CH_SLASH || op == CH_PCT) && top != '0) begin
          state_next = S_DIV;
        end else if (op == CH_CARET && !top[31]) begin
          state_next = S_POW_MUL;
        end else begin
          state_next = last ? S_EMIT : S_IDLE;
        end
      end
      S_DIV: begin
        if (div_cnt == '0) begin
          state_next = S_DFIX;
        end
      end
      S_DFIX: state_next = last ? S_EMIT : S_IDLE;
      S_POW_MUL: begin
        if (opb == '0) begin
          state_next = last ? S_EMIT : S_IDLE;
        end else begin
          state_next = S_POW_SQ;
        end
      end
      S_POW_SQ: state_next = S_POW_MUL;
      S_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      depth         <= '0;
      err           <= ST_OK;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_EMIT && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op   <= s_axis_tdata;
            last <= s_axis_tlast;
            if (is_digit) begin
              if (depth < DW'(STACK_DEPTH)) begin
                top   <= {24'd0, s_axis_tdata - CH_ZERO};
                depth <= depth + DW'(1);
              end else begin
                err <= err_ovf;
              end
            end else if (is_op) begin
              if (depth >= DW'(2)) begin
                depth <= depth_m1;
              end else begin
                err <= err_und;
              end
            end
          end
        end
        S_EXEC: begin
          case (op)
            CH_PLUS:  top <= ram_rdata + top;
            CH_MINUS: top <= ram_rdata - top;
            CH_STAR:  top <= mul_p;
            CH_CARET: begin
              if (top[31]) begin
                if (ram_rdata == 32'd1) begin
                  top <= 32'd1;
                end else if (ram_rdata == 32'hFFFF_FFFF) begin
                  top <= top[0] ? 32'hFFFF_FFFF : 32'd1;
                end else begin
                  top <= '0;
                end
              end else begin
                opa <= ram_rdata;
                opb <= top;
                quo <= 32'd1;
              end
            end
            default: begin
              ysign   <= ram_rdata[31];
              xsign   <= top[31];
              opb     <= top[31] ? (32'd0 - top) : top;
              rem     <= '0;
              quo     <= ram_rdata[31] ? (32'd0 - ram_rdata) : ram_rdata;
              div_cnt <= 5'd31;
              if (top == '0) begin
                err <= err_div;
              end
            end
          endcase
        end
        S_DIV: begin
          div_cnt <= div_cnt - 5'd1;
          quo     <= {quo[30:0], !div_trial[32]};
          rem     <= div_trial[32] ? div_sh[31:0] : div_trial[31:0];
        end
        S_DFIX: begin
          if (op == CH_SLASH) begin
            top <= (ysign != xsign) ? (32'd0 - quo) : quo;
          end else begin
            top <= ysign ? (32'd0 - rem) : rem;
          end
        end
        S_POW_MUL: begin
          if (opb == '0) begin
            top <= quo;
          end else if (opb[0]) begin
            quo <= mul_p;
          end
        end
        S_POW_SQ: begin
          opa <= mul_p;
          opb <= {1'b0, opb[31:1]};
        end
        S_EMIT: begin
          if (out_free) begin
            m_axis_tdata[31:0]   <= (depth != '0) ? top : 32'd0;
            m_axis_tdata[34:32]  <= (err != ST_OK) ? err :
                                    ((depth == '0) ? ST_EMPTY : ST_OK);
            m_axis_tdata[39:35]  <= '0;
            depth                <= '0;
            err                  <= ST_OK;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import pse_pkg::*;

  localparam int DEPTH = 32;
  localparam int NUM_ITEMS = 1400;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct {
    bit [31:0] value;
    bit [2:0]  status;
  } expr_result_t;

  class expr_scoreboard;
    bit [31:0]    operands [DEPTH];
    int unsigned  depth;
    bit [2:0]     err;
    expr_result_t pending [$];
    int unsigned  errors;
    int unsigned  exprs;
    int unsigned  checked;
    int unsigned  status_hits [5];

    static function bit is_digit(bit [7:0] ch);
      return ch >= CH_ZERO && ch <= CH_NINE;
    endfunction

    static function bit is_op(bit [7:0] ch);
      return ch == CH_PLUS || ch == CH_MINUS || ch == CH_STAR ||
             ch == CH_SLASH || ch == CH_PCT || ch == CH_CARET;
    endfunction

    function void flag(bit [2:0] code);
      if (err == ST_OK) err = code;
    endfunction

    function bit [31:0] raise(bit [31:0] base, bit [31:0] expo);
      bit [31:0] acc;
      acc = 1;
      if (expo[31]) begin
        if (base == 32'd1) return 1;
        if (base == 32'hFFFF_FFFF) return expo[0] ? 32'hFFFF_FFFF : 32'd1;
        return 0;
      end
      while (expo != 0) begin
        if (expo[0]) acc = acc * base;
        base = base * base;
        expo = expo >> 1;
      end
      return acc;
    endfunction

    // truncating signed divide on magnitudes; wraps for MIN / -1
    function bit [31:0] divmod(bit [31:0] y, bit [31:0] x, bit want_rem);
      bit [31:0] ym, xm, q, r;
      ym = y[31] ? -y : y;
      xm = x[31] ? -x : x;
      q = ym / xm;
      r = ym % xm;
      if (want_rem) return y[31] ? -r : r;
      return (y[31] != x[31]) ? -q : q;
    endfunction

    function void note_input(bit [7:0] ch, bit last);
      bit [31:0] x, y, r;
      expr_result_t res;
      if (is_digit(ch)) begin
        if (depth >= DEPTH) flag(ST_OVERFLOW);
        else begin
          operands[depth] = 32'(ch - CH_ZERO);
          depth++;
        end
      end else if (is_op(ch)) begin
        if (depth < 2) flag(ST_UNDERFLOW);
        else begin
          x = operands[depth-1];
          y = operands[depth-2];
          case (ch)
            CH_PLUS:  r = y + x;
            CH_MINUS: r = y - x;
            CH_STAR:  r = y * x;
            CH_CARET: r = raise(y, x);
            default: begin
              if (x == 0) begin
                r = 0;
                flag(ST_DIVZERO);
              end else r = divmod(y, x, ch == CH_PCT);
            end
          endcase
          depth--;
          operands[depth-1] = r;
        end
      end
      if (last) begin
        res.value = 0;
        res.status = err;
        if (depth > 0) res.value = operands[depth-1];
        else if (err == ST_OK) res.status = ST_EMPTY;
        pending.push_back(res);
        depth = 0;
        err = ST_OK;
        exprs++;
      end
    endfunction

    function void check_result(bit [39:0] data);
      expr_result_t exp_res;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: value %h status %0d", data[31:0], data[34:32]);
        return;
      end
      exp_res = pending.pop_front();
      checked++;
      if (exp_res.status <= ST_EMPTY) status_hits[exp_res.status]++;
      if (data[31:0] != exp_res.value || data[34:32] != exp_res.status) begin
        errors++;
        if (errors <= 10)
          $display("result %0d: value exp %h got %h, status exp %0d got %0d",
                   checked, exp_res.value, data[31:0], exp_res.status, data[34:32]);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] char_code
  logic        s_axis_tlast;   // end_of_expr
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // [31:0] value, [34:32] status

  expr_scoreboard sb = new();
  bit [7:0]       expr_chars [$];
  int unsigned    items_sent;
  int unsigned    cycles;
  bit             calm;

  postfix_stack_evaluator_unit #(.STACK_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata));

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tdata, s_axis_tlast);
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic bit [7:0] rand_digit();
    if ($urandom_range(0, 24) == 0) return CH_ZERO;
    return CH_ZERO + 8'($urandom_range(1, 9));
  endfunction

  function automatic bit [7:0] rand_op();
    case ($urandom_range(0, 5))
      0: return CH_PLUS;
      1: return CH_MINUS;
      2: return CH_STAR;
      3: return CH_SLASH;
      4: return CH_PCT;
      default: return CH_CARET;
    endcase
  endfunction

  function automatic bit [7:0] rand_noise();
    bit [7:0] c;
    do begin
      if ($urandom_range(0, 2) == 0) c = 8'($urandom_range(8'h61, 8'h7A));
      else c = 8'($urandom_range(0, 255));
    end while (expr_scoreboard::is_digit(c) || expr_scoreboard::is_op(c));
    return c;
  endfunction

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) expr_chars.push_back(s[i]);
  endtask

  task automatic send_char(bit [7:0] ch, bit last);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= ch;
    s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic send_expr();
    for (int i = 0; i < expr_chars.size(); i++) begin
      if (expr_scoreboard::is_digit(expr_chars[i]) || expr_scoreboard::is_op(expr_chars[i]))
        items_sent++;
      send_char(expr_chars[i], i == expr_chars.size() - 1);
    end
    expr_chars.delete();
  endtask

  task automatic build_wellformed();
    int ops, pushes, level;
    ops = $urandom_range(1, 10);
    pushes = ops + 1;
    level = 0;
    while (pushes + ops > 0) begin
      if ($urandom_range(0, 9) == 0) expr_chars.push_back(rand_noise());
      if (pushes > 0 && (level < 2 || $urandom_range(0, 1))) begin
        expr_chars.push_back(rand_digit());
        pushes--;
        level++;
      end else begin
        expr_chars.push_back(rand_op());
        ops--;
        level--;
      end
    end
    if ($urandom_range(0, 7) == 0) expr_chars.push_back(rand_noise());
  endtask

  task automatic build_deep();
    repeat ($urandom_range(28, 36)) expr_chars.push_back(rand_digit());
    repeat ($urandom_range(0, 6)) expr_chars.push_back(rand_op());
  endtask

  task automatic build_broken();
    repeat ($urandom_range(1, 10))
      expr_chars.push_back($urandom_range(0, 1) ? rand_digit() : rand_op());
  endtask

  task automatic build_corner();
    case ($urandom_range(0, 2))
      0: begin
        // most negative value against -1
        add_text("239*4+^01-");
        expr_chars.push_back($urandom_range(0, 1) ? CH_SLASH : CH_PCT);
      end
      1: begin
        case ($urandom_range(0, 2))
          0: add_text("1");
          1: add_text("01-");
          default: expr_chars.push_back(rand_digit());
        endcase
        if ($urandom_range(0, 3) == 0) add_text("0");
        else begin
          add_text("0");
          expr_chars.push_back(CH_ZERO + 8'($urandom_range(1, 9)));
          add_text("-");
        end
        add_text("^");
      end
      default: begin
        add_text("99^");
        if ($urandom_range(0, 1)) add_text("099^-");
        else expr_chars.push_back(rand_digit());
        expr_chars.push_back(rand_op());
      end
    endcase
  endtask

  initial begin
    int unsigned pick;
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = 0;
    s_axis_tlast = 0;
    calm = 1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    add_text("95-3*8+2^7/5%"); send_expr();
    add_text("20/"); send_expr();
    add_text("+"); send_expr();
    add_text("201-^"); send_expr();
    add_text("00^"); send_expr();
    add_text("7"); send_expr();
    expr_chars.push_back(8'h41); expr_chars.push_back(8'h00); send_expr();
    expr_chars.push_back(8'hFF); send_expr();

    while (items_sent < NUM_ITEMS) begin
      calm = ($urandom_range(0, 9) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 65) build_wellformed();
      else if (pick < 75) build_deep();
      else if (pick < 85) build_broken();
      else if (pick < 93) build_corner();
      else repeat ($urandom_range(1, 4)) expr_chars.push_back(rand_noise());
      send_expr();
    end
    s_axis_tvalid <= 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d expressions, %0d operand/operator transfers, %0d results checked",
             sb.exprs, items_sent, sb.checked);
    $display("status mix: ok %0d, underflow %0d, overflow %0d, div-by-zero %0d, empty %0d",
             sb.status_hits[0], sb.status_hits[1], sb.status_hits[2],
             sb.status_hits[3], sb.status_hits[4]);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    int unsigned gap;
    m_axis_tready = 0;
    @(negedge rst);
    @(negedge clk);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        m_axis_tready <= 0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready <= 1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

endmodule

>>> files.f
hw/rtl/pse_pkg.sv
hw/rtl/pse_ram.sv
hw/rtl/postfix_stack_evaluator_unit.sv
verif/tb.sv
